### rtl/nbacc_pkg.sv
// Shared types and constants of the n-body acceleration accumulator.
`timescale 1ns / 1ps
package nbacc_pkg;

	localparam int POS_W  = 32;
	localparam int DIF_W  = 33;
	localparam int D2_W   = 66;
	localparam int RT_W   = 34;
	localparam int DEN_W  = 100;
	localparam int GM_W   = 64;
	localparam int PW     = 121;
	localparam int NUM_SH = 24;
	localparam int OUT_W  = 48;
	localparam int SQ_STEPS  = 34;
	localparam int DIV_STEPS = 121;

	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_MUL_INIT = 4'd2;
	localparam logic [3:0] OP_MUL_STEP = 4'd3;
	localparam logic [3:0] OP_SAVE_D2  = 4'd4;
	localparam logic [3:0] OP_SQ_INIT  = 4'd5;
	localparam logic [3:0] OP_SQ_STEP  = 4'd6;
	localparam logic [3:0] OP_SAVE_DEN = 4'd7;
	localparam logic [3:0] OP_SAVE_GM  = 4'd8;
	localparam logic [3:0] OP_DIV_INIT = 4'd9;
	localparam logic [3:0] OP_DIV_STEP = 4'd10;
	localparam logic [3:0] OP_ACCUM    = 4'd11;
	localparam logic [3:0] OP_EMIT     = 4'd12;

	localparam logic [2:0] SEL_DX  = 3'd0;
	localparam logic [2:0] SEL_DY  = 3'd1;
	localparam logic [2:0] SEL_DZ  = 3'd2;
	localparam logic [2:0] SEL_DEN = 3'd3;
	localparam logic [2:0] SEL_GM  = 3'd4;
	localparam logic [2:0] SEL_NUM = 3'd5;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] sel;
		logic [1:0] axis;
	} nbacc_cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
		logic d2_zero;
		logic mul_busy;
	} nbacc_stat_t;

endpackage

### rtl/nbacc_ctrl.sv
// Sequencer for loading, multiply, root, divide and accumulate steps.
`timescale 1ns / 1ps
module nbacc_ctrl
	import nbacc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  nbacc_stat_t stat,
	output nbacc_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_MX   = 4'd2;
	localparam logic [3:0] S_MY   = 4'd3;
	localparam logic [3:0] S_MZ   = 4'd4;
	localparam logic [3:0] S_ZCHK = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_DENI = 4'd7;
	localparam logic [3:0] S_DEN  = 4'd8;
	localparam logic [3:0] S_GMI  = 4'd9;
	localparam logic [3:0] S_GM   = 4'd10;
	localparam logic [3:0] S_NUMI = 4'd11;
	localparam logic [3:0] S_NUM  = 4'd12;
	localparam logic [3:0] S_DIV  = 4'd13;
	localparam logic [3:0] S_ACC  = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0] state_q, state_d;
	logic [6:0] cnt_q, cnt_d;
	logic [1:0] axis_q, axis_d;
	logic       ovld_q, ovld_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovld_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		axis_d   = axis_q;
		ovld_d   = ovld_q && !out_ready;
		cmd.op   = OP_NONE;
		cmd.sel  = SEL_DX;
		cmd.axis = axis_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.skip) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_MUL_INIT;
					cmd.sel = SEL_DX;
					state_d = S_MX;
				end
			end
			S_MX: begin
				if (stat.mul_busy) begin
					cmd.op = OP_MUL_STEP;
				end else begin
					cmd.op  = OP_MUL_INIT;
					cmd.sel = SEL_DY;
					state_d = S_MY;
				end
			end
			S_MY: begin
				if (stat.mul_busy) begin
					cmd.op = OP_MUL_STEP;
				end else begin
					cmd.op  = OP_MUL_INIT;
					cmd.sel = SEL_DZ;
					state_d = S_MZ;
				end
			end
			S_MZ: begin
				if (stat.mul_busy) begin
					cmd.op = OP_MUL_STEP;
				end else begin
					cmd.op  = OP_SAVE_D2;
					state_d = S_ZCHK;
				end
			end
			S_ZCHK: begin
				if (stat.d2_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_SQ_INIT;
					cnt_d   = '0;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQ_STEP;
				cnt_d  = cnt_q + 7'd1;
				if (cnt_q == 7'(SQ_STEPS - 1)) state_d = S_DENI;
			end
			S_DENI: begin
				cmd.op  = OP_MUL_INIT;
				cmd.sel = SEL_DEN;
				state_d = S_DEN;
			end
			S_DEN: begin
				if (stat.mul_busy) begin
					cmd.op = OP_MUL_STEP;
				end else begin
					cmd.op  = OP_SAVE_DEN;
					state_d = S_GMI;
				end
			end
			S_GMI: begin
				cmd.op  = OP_MUL_INIT;
				cmd.sel = SEL_GM;
				state_d = S_GM;
			end
			S_GM: begin
				if (stat.mul_busy) begin
					cmd.op = OP_MUL_STEP;
				end else begin
					cmd.op  = OP_SAVE_GM;
					axis_d  = '0;
					state_d = S_NUMI;
				end
			end
			S_NUMI: begin
				cmd.op  = OP_MUL_INIT;
				cmd.sel = SEL_NUM;
				state_d = S_NUM;
			end
			S_NUM: begin
				if (stat.mul_busy) begin
					cmd.op = OP_MUL_STEP;
				end else begin
					cmd.op  = OP_DIV_INIT;
					cnt_d   = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_STEPS - 1)) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op = OP_ACCUM;
				if (axis_q == 2'd2) begin
					state_d = S_DONE;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_NUMI;
				end
			end
			S_DONE: begin
				if (!stat.last) begin
					state_d = S_IDLE;
				end else if (!ovld_q || out_ready) begin
					cmd.op  = OP_EMIT;
					ovld_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			ovld_q  <= ovld_d;
		end
	end

endmodule

### rtl/nbacc_dpath.sv
// Datapath: serial multiplier, root, divider, saturating sums and result register.
`timescale 1ns / 1ps
module nbacc_dpath
	import nbacc_pkg::*;
#(
	parameter int ACC_WIDTH = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nbacc_cmd_t              cmd,
	output nbacc_stat_t             stat,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_data,
	input  logic [7*POS_W-1:0]      in_data,
	input  logic                    in_skip,
	input  logic                    in_last,
	output logic [3*OUT_W-1:0]      out_data,
	output logic                    out_ovf
);

	logic [31:0]          grav_q;
	logic [31:0]          mass_q;
	logic [DIF_W-1:0]     dabs_q [3];
	logic [2:0]           dneg_q;
	logic                 skip_q, last_q;
	logic [PW-1:0]        pa_q, pp_q;
	logic [D2_W-1:0]      pb_q;
	logic [D2_W-1:0]      d2_q;
	logic [D2_W+1:0]      sq_q;
	logic [RT_W+1:0]      srem_q;
	logic [RT_W-1:0]      root_q;
	logic [DEN_W-1:0]     den_q;
	logic [GM_W-1:0]      gm_q;
	logic [PW-1:0]        num_q, quo_q;
	logic [DEN_W:0]       drem_q;
	logic signed [ACC_WIDTH-1:0] sum_q [3];
	logic                 sat_q;
	logic [3*OUT_W-1:0]   out_q;
	logic                 ovf_q;

	logic signed [DIF_W-1:0] dif [3];
	logic [RT_W+3:0]      sq_t, sq_trial;
	logic [DEN_W:0]       dv_t;
	logic                 dv_ge;
	logic [PW-1:0]        lim;
	logic                 neg, tsat, ssat;
	logic [ACC_WIDTH-1:0] mag;
	logic signed [ACC_WIDTH-1:0] term, cur, nsum;
	logic signed [ACC_WIDTH:0]   wsum;
	logic [DIF_W-1:0]     dsel;
	logic signed [63:0]   ext [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = DIF_W'(signed'(in_data[(i+3)*POS_W +: POS_W]))
				- DIF_W'(signed'(in_data[i*POS_W +: POS_W]));
		end
	end

	always_comb begin
		unique case (cmd.axis)
			2'd0:    begin dsel = dabs_q[0]; neg = dneg_q[0]; cur = sum_q[0]; end
			2'd1:    begin dsel = dabs_q[1]; neg = dneg_q[1]; cur = sum_q[1]; end
			default: begin dsel = dabs_q[2]; neg = dneg_q[2]; cur = sum_q[2]; end
		endcase
	end

	assign sq_t     = {srem_q, sq_q[D2_W+1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign dv_t     = {drem_q[DEN_W-1:0], num_q[PW-1]};
	assign dv_ge    = dv_t >= {1'b0, den_q};

	always_comb begin
		lim  = PW'({1'b0, {(ACC_WIDTH-1){1'b1}}}) + PW'(neg);
		tsat = quo_q > lim;
		mag  = tsat ? lim[ACC_WIDTH-1:0] : quo_q[ACC_WIDTH-1:0];
		term = neg ? -signed'(mag) : signed'(mag);
		wsum = {cur[ACC_WIDTH-1], cur} + {term[ACC_WIDTH-1], term};
		ssat = wsum[ACC_WIDTH] != wsum[ACC_WIDTH-1];
		if (ssat) begin
			nsum = wsum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			nsum = wsum[ACC_WIDTH-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) ext[i] = 64'(sum_q[i]);
	end

	assign stat.skip     = skip_q;
	assign stat.last     = last_q;
	assign stat.d2_zero  = (d2_q == '0);
	assign stat.mul_busy = (pb_q != '0);
	assign out_data      = out_q;
	assign out_ovf       = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= '0;
			sum_q  <= '{default: '0};
			sat_q  <= 1'b0;
		end else begin
			if (cfg_we) grav_q <= cfg_data;
			if (cmd.op == OP_ACCUM) begin
				unique case (cmd.axis)
					2'd0:    sum_q[0] <= nsum;
					2'd1:    sum_q[1] <= nsum;
					default: sum_q[2] <= nsum;
				endcase
				if (tsat || ssat) sat_q <= 1'b1;
			end else if (cmd.op == OP_EMIT) begin
				sum_q <= '{default: '0};
				sat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					dabs_q[i] <= dif[i][DIF_W-1] ? DIF_W'(-dif[i]) : DIF_W'(dif[i]);
					dneg_q[i] <= dif[i][DIF_W-1];
				end
				mass_q <= in_data[6*POS_W +: POS_W];
				skip_q <= in_skip;
				last_q <= in_last;
			end
			OP_MUL_INIT: begin
				unique case (cmd.sel)
					SEL_DX: begin
						pa_q <= PW'(dabs_q[0]); pb_q <= D2_W'(dabs_q[0]); pp_q <= '0;
					end
					SEL_DY: begin
						pa_q <= PW'(dabs_q[1]); pb_q <= D2_W'(dabs_q[1]);
					end
					SEL_DZ: begin
						pa_q <= PW'(dabs_q[2]); pb_q <= D2_W'(dabs_q[2]);
					end
					SEL_DEN: begin
						pa_q <= PW'(d2_q); pb_q <= D2_W'(root_q); pp_q <= '0;
					end
					SEL_GM: begin
						pa_q <= PW'(grav_q); pb_q <= D2_W'(mass_q); pp_q <= '0;
					end
					default: begin
						pa_q <= PW'(gm_q); pb_q <= D2_W'(dsel); pp_q <= '0;
					end
				endcase
			end
			OP_MUL_STEP: begin
				if (pb_q[0]) pp_q <= pp_q + pa_q;
				pa_q <= pa_q << 1;
				pb_q <= pb_q >> 1;
			end
			OP_SAVE_D2: d2_q <= pp_q[D2_W-1:0];
			OP_SQ_INIT: begin
				sq_q   <= {2'b00, d2_q};
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQ_STEP: begin
				sq_q <= sq_q << 2;
				if (sq_t >= sq_trial) begin
					srem_q <= (RT_W+2)'(sq_t - sq_trial);
					root_q <= {root_q[RT_W-2:0], 1'b1};
				end else begin
					srem_q <= (RT_W+2)'(sq_t);
					root_q <= {root_q[RT_W-2:0], 1'b0};
				end
			end
			OP_SAVE_DEN: den_q <= pp_q[DEN_W-1:0];
			OP_SAVE_GM:  gm_q  <= pp_q[GM_W-1:0];
			OP_DIV_INIT: begin
				num_q  <= {pp_q[PW-NUM_SH-1:0], {NUM_SH{1'b0}}};
				drem_q <= '0;
				quo_q  <= '0;
			end
			OP_DIV_STEP: begin
				num_q  <= num_q << 1;
				drem_q <= dv_ge ? dv_t - {1'b0, den_q} : dv_t;
				quo_q  <= {quo_q[PW-2:0], dv_ge};
			end
			OP_EMIT: begin
				out_q <= {ext[2][OUT_W-1:0], ext[1][OUT_W-1:0], ext[0][OUT_W-1:0]};
				ovf_q <= sat_q;
			end
			default: ;
		endcase
	end

endmodule

### rtl/nbody_acceleration_accumulator.sv
// Top level of the n-body acceleration accumulator.
// Input stream s_axis: one item per source body of a target. tdata carries the
// target and source positions (signed Q16.16) and the source mass, tuser the
// skip flag, tlast marks the final source of the target's list.
// Output stream m_axis: one item per list, holding the three saturated Q24.24
// acceleration sums in tdata and the overflow flag in tuser.
// Configuration: cfg_valid/cfg_data write the Q0.32 gravitational constant;
// cfg_ready is always high. Write it only while the block is idle.
// Sequence: a skipped item goes straight to the end-of-item check. Otherwise the
// squared distance on the shift-add multiplier, the zero check and the integer
// root, the denominator and the mass product, then per axis the numerator, the
// restoring divider and the accumulation.
// One item is worked on at a time; s_axis_tready is high only when idle.
// A finished result is held in an output register; the next item is accepted
// while it waits, and the block stalls only at the following list end until
// the receiver takes it. Reset clears the sums, flag, constant and valid.
`timescale 1ns / 1ps
module nbody_acceleration_accumulator
	import nbacc_pkg::*;
#(
	parameter int ACC_WIDTH = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tgt_x, tgt_y, tgt_z, src_x, src_y, src_z, src_mass
	input  logic [223:0] s_axis_tdata,
	// skip
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// acc_x, acc_y, acc_z
	output logic [143:0] m_axis_tdata,
	// overflow
	output logic         m_axis_tuser
);

	nbacc_cmd_t  cmd;
	nbacc_stat_t stat;

	assign cfg_ready = 1'b1;

	nbacc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nbacc_dpath #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.in_data  (s_axis_tdata),
		.in_skip  (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.out_data (m_axis_tdata),
		.out_ovf  (m_axis_tuser)
	);

endmodule

### dv/nbody_acceleration_accumulator_tb.sv
// Self-checking testbench for the n-body acceleration accumulator: directed table plus random lists.
`timescale 1ns / 1ps
module nbody_acceleration_accumulator_tb;
	import nbacc_pkg::*;

	localparam int ACC_W = 48;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic signed [31:0] tx, ty, tz, sx, sy, sz;
		logic [31:0] mass;
		logic skip, last;
	} body_t;

	typedef struct {
		logic [47:0] ax, ay, az;
		logic ovf;
	} accel_t;

	typedef struct {
		body_t b;
		logic has_exp;
		accel_t e;
	} row_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [31:0] cfg_data;
	logic s_axis_tvalid, s_axis_tready;
	logic [223:0] s_axis_tdata;
	logic s_axis_tuser, s_axis_tlast;
	logic m_axis_tvalid, m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic m_axis_tuser;

	nbody_acceleration_accumulator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	logic [31:0] g_const;
	logic signed [63:0] acc_x, acc_y, acc_z;
	logic sat_flag;
	accel_t accel_q[$];
	int errors = 0;
	int lists = 0;
	int hold_cycles = 0;
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("nbody_acceleration_accumulator verification failed");
			$finish;
		end
	end

	function automatic logic signed [63:0] acc_lim(input logic neg);
		logic signed [63:0] mx;
		mx = (64'sd1 <<< (ACC_W - 1)) - 1;
		return neg ? -mx - 1 : mx;
	endfunction

	function automatic logic signed [63:0] axis_term(input logic signed [33:0] d,
			input logic [65:0] d2, input logic [33:0] s, input logic [63:0] gm);
		logic [32:0] mag;
		logic [127:0] num, den, q;
		logic [63:0] lim;
		mag = d < 0 ? -d : d;
		num = ({64'd0, gm} * {95'd0, mag}) << 24;
		den = {62'd0, d2} * {94'd0, s};
		q = num / den;
		lim = d < 0 ? acc_lim(0) + 1 : acc_lim(0);
		if (q > {64'd0, lim}) begin
			sat_flag = 1;
			q = {64'd0, lim};
		end
		return d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
			input logic signed [63:0] t);
		logic signed [63:0] r;
		r = a + t;
		if (r > acc_lim(0)) begin
			sat_flag = 1;
			return acc_lim(0);
		end
		if (r < acc_lim(1)) begin
			sat_flag = 1;
			return acc_lim(1);
		end
		return r;
	endfunction

	function automatic logic [33:0] isqrt(input logic [65:0] v);
		logic [33:0] s, c;
		s = 0;
		for (int i = 33; i >= 0; i--) begin
			c = s | (34'd1 << i);
			if ({34'd0, c} * {34'd0, c} <= {2'd0, v}) s = c;
		end
		return s;
	endfunction

	function automatic logic predict_accel(input body_t b, output accel_t r);
		logic signed [33:0] dx, dy, dz;
		logic [65:0] d2;
		logic [33:0] s;
		logic [63:0] gm;
		if (!b.skip) begin
			dx = 34'(b.sx) - 34'(b.tx);
			dy = 34'(b.sy) - 34'(b.ty);
			dz = 34'(b.sz) - 34'(b.tz);
			d2 = 66'($unsigned(68'(dx) * 68'(dx))) + 66'($unsigned(68'(dy) * 68'(dy)))
				+ 66'($unsigned(68'(dz) * 68'(dz)));
			if (d2 != 0) begin
				s = isqrt(d2);
				gm = {32'd0, g_const} * {32'd0, b.mass};
				acc_x = sat_sum(acc_x, axis_term(dx, d2, s, gm));
				acc_y = sat_sum(acc_y, axis_term(dy, d2, s, gm));
				acc_z = sat_sum(acc_z, axis_term(dz, d2, s, gm));
			end
		end
		if (!b.last) return 0;
		r.ax = acc_x[47:0];
		r.ay = acc_y[47:0];
		r.az = acc_z[47:0];
		r.ovf = sat_flag;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		sat_flag = 0;
		return 1;
	endfunction

	task automatic send_body(input body_t b, input logic has_exp, input accel_t e);
		accel_t r;
		int gap;
		s_axis_tdata <= {b.mass, b.sz, b.sy, b.sx, b.tz, b.ty, b.tx};
		s_axis_tuser <= b.skip;
		s_axis_tlast <= b.last;
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (predict_accel(b, r)) accel_q.push_back(has_exp ? e : r);
		gap = 0;
		if ($urandom_range(0, 3) == 0)
			gap = $urandom_range(0, 9) == 0 ? $urandom_range(20, 200) : $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_grav(input logic [31:0] v);
		s_axis_tvalid <= 0;
		while (accel_q.size() != 0) @(negedge clk);
		repeat (800) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		g_const = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic body_t rand_body(input int mode);
		body_t b;
		b.tx = $urandom;
		b.ty = $urandom;
		b.tz = $urandom;
		if (mode == 0) begin
			b.sx = b.tx + $signed($urandom_range(0, 2 ** 22) - 2 ** 21);
			b.sy = b.ty + $signed($urandom_range(0, 2 ** 22) - 2 ** 21);
			b.sz = b.tz + $signed($urandom_range(0, 2 ** 22) - 2 ** 21);
		end else begin
			b.sx = $urandom;
			b.sy = $urandom;
			b.sz = $urandom;
		end
		b.mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
		b.skip = $urandom_range(0, 7) == 0;
		b.last = $urandom_range(0, 4) == 0;
		return b;
	endfunction

	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
	end

	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0)
				m_axis_tready <= 0;
			else if ($urandom_range(0, 19) == 0)
				m_axis_tready <= 0;
			else if ($urandom_range(0, 1) == 0 || !m_axis_tready)
				m_axis_tready <= $urandom_range(0, 4) != 0;
		end
	end

	always @(posedge clk) begin
		accel_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			lists++;
			if (accel_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h %b", $time, m_axis_tdata, m_axis_tuser);
			end else begin
				e = accel_q.pop_front();
				if (m_axis_tdata !== {e.az, e.ay, e.ax} || m_axis_tuser !== e.ovf) begin
					errors++;
					$display("%0t: expected %h %b, got %h %b", $time,
						{e.az, e.ay, e.ax}, e.ovf, m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	row_t dir_rows[$];

	task automatic add_row(input logic signed [31:0] tx, ty, tz, sx, sy, sz,
			input logic [31:0] m, input logic sk, lst, input logic he, input accel_t e);
		row_t r;
		r.b = '{tx, ty, tz, sx, sy, sz, m, sk, lst};
		r.has_exp = he;
		r.e = e;
		dir_rows.push_back(r);
	endtask

	initial begin
		accel_t z0, zz;
		body_t b;
		int sent;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		s_axis_tlast = 0;
		g_const = 0;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		sat_flag = 0;
		z0 = '{48'd0, 48'd0, 48'd0, 1'b0};
		zz = z0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// constant still zero after reset
		add_row(0, 0, 0, 32'sd65536, 0, 0, 32'hFFFFFFFF, 0, 1, 1, z0);
		add_row(0, 0, 0, 0, 0, 0, 100, 0, 1, 1, z0);
		add_row(5, 5, 5, 9, 9, 9, 7, 1, 1, 1, z0);
		foreach (dir_rows[i]) send_body(dir_rows[i].b, dir_rows[i].has_exp, dir_rows[i].e);
		dir_rows.delete();

		write_grav(32'hFFFFFFFF);
		add_row(0, 0, 0, 1, 0, 0, 32'hFFFFFFFF, 0, 0, 0, zz);
		add_row(0, 0, 0, 0, 1, 0, 32'hFFFFFFFF, 0, 0, 0, zz);
		add_row(0, 0, 0, 0, 0, 1, 32'hFFFFFFFF, 0, 1, 0, zz);
		add_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'hFFFFFFFF, 0, 1, 0, zz);
		add_row(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0, 1, 0, zz);
		add_row(100, 100, 100, 100, 100, 100, 5000, 0, 0, 0, zz);
		add_row(100, 100, 100, 100, 100, 100, 5000, 1, 1, 0, zz);
		add_row(0, 0, 0, -32'sd65536, 32'sd65536, -32'sd3, 12345, 0, 1, 0, zz);
		add_row(0, 0, 0, 2, 0, 0, 0, 0, 1, 0, zz);
		foreach (dir_rows[i]) send_body(dir_rows[i].b, dir_rows[i].has_exp, dir_rows[i].e);
		dir_rows.delete();

		write_grav(32'd1);
		add_row(0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536, 32'hFFFFFFFF, 0, 0, 0, zz);
		add_row(7, -7, 3, -3, 11, 0, 32'd99999, 0, 1, 0, zz);
		foreach (dir_rows[i]) send_body(dir_rows[i].b, dir_rows[i].has_exp, dir_rows[i].e);
		dir_rows.delete();

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			write_grav(phase == 0 ? 32'h0000_1000 : phase == 3 ? 32'hFFFFFFFF : $urandom);
			for (int i = 0; i < 110; i++) begin
				if (phase == 1 && i == 20) hold_cycles = 20000;
				b = rand_body($urandom_range(0, 3) == 0);
				if (i == 109) b.last = 1;
				send_body(b, 0, zz);
				sent++;
			end
		end

		s_axis_tvalid <= 0;
		while (accel_q.size() != 0) @(negedge clk);
		repeat (1000) @(negedge clk);
		$display("sent %0d random bodies plus directed rows, checked %0d results", sent, lists);
		$display("constant varied over zero, one, midrange and full scale");
		if (errors == 0)
			$display("nbody_acceleration_accumulator verification clean");
		else
			$display("nbody_acceleration_accumulator verification failed");
		$finish;
	end

endmodule

### sim.f
rtl/nbacc_pkg.sv
rtl/nbacc_ctrl.sv
rtl/nbacc_dpath.sv
rtl/nbody_acceleration_accumulator.sv
dv/nbody_acceleration_accumulator_tb.sv
